// ----- hw/rtl/spfc_pkg.sv -----
package spfc_pkg;

  // frame layout
  localparam int unsigned CntW          = 9;
  localparam logic [CntW-1:0] CntMax    = '1;
  localparam logic [CntW-1:0] MinFrame  = 9'd6;
  localparam logic [CntW-1:0] PosId     = 9'd2;
  localparam logic [CntW-1:0] PosLength = 9'd3;
  localparam logic [CntW-1:0] PosInstr  = 9'd4;
  localparam logic [CntW-1:0] PosParam  = 9'd5;
  localparam logic [7:0] HeaderByte     = 8'hFF;
  localparam logic [7:0] MinLength     = 8'd2;
  localparam logic [7:0] MinLengthParm = 8'd3;
  localparam logic [CntW-1:0] LenOverhead = 9'd4;
  localparam int unsigned StatusBit     = 7;

  typedef enum logic [2:0] {
    VERDICT_OK            = 3'd0,
    VERDICT_TOO_SHORT     = 3'd1,
    VERDICT_BAD_HEADER    = 3'd2,
    VERDICT_BAD_LENGTH    = 3'd3,
    VERDICT_SIZE_MISMATCH = 3'd4,
    VERDICT_BAD_CHECKSUM  = 3'd5,
    VERDICT_NOT_STATUS    = 3'd6
  } verdict_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    verdict_e   verdict;
    logic [7:0] servo_id;
    logic [7:0] instruction_code;
    logic [7:0] length_field;
    logic       is_status;
    logic [7:0] servo_error;
    logic [7:0] param_count;
  } result_t;

endpackage

// ----- hw/rtl/spfc_in_if.sv -----
interface spfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- hw/rtl/spfc_out_if.sv -----
interface spfc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] verdict;
  logic [7:0] servo_id;
  logic [7:0] instruction_code;
  logic [7:0] length_field;
  logic       is_status;
  logic [7:0] servo_error;
  logic [7:0] param_count;

  modport source (
    output valid, output verdict, output servo_id, output instruction_code,
    output length_field, output is_status, output servo_error, output param_count,
    input ready
  );
  modport sink (
    input valid, input verdict, input servo_id, input instruction_code,
    input length_field, input is_status, input servo_error, input param_count,
    output ready
  );
endinterface

// ----- hw/rtl/spfc_input_reg.sv -----
module spfc_input_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  spfc_in_if.sink         in_i,
  input  logic            adv_i,
  output logic            valid_o,
  output spfc_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  spfc_pkg::item_t item_q;
  logic            load;

  assign in_i.ready = !valid_q || adv_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.data_byte <= in_i.data_byte;
      item_q.last_byte <= in_i.last_byte;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- hw/rtl/spfc_frame_core.sv -----
module spfc_frame_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  spfc_pkg::item_t   item_i,
  input  logic              req_status_i,
  output spfc_pkg::result_t res_o
);

  logic [spfc_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                      hdr_q, hdr_d;
  logic [7:0]                sum_q, sum_d;
  logic [7:0]                id_q, id_d;
  logic [7:0]                len_q, len_d;
  logic [7:0]                ins_q, ins_d;
  logic [7:0]                fp_q, fp_d;

  // fields with the current byte folded in
  logic                      hdr_n;
  logic [7:0]                id_n, len_n, ins_n, fp_n;
  logic [spfc_pkg::CntW-1:0] size;
  logic [spfc_pkg::CntW-1:0] len_plus;
  logic                      status;
  logic                      sound;
  spfc_pkg::verdict_e        verdict;
  logic [7:0]                b;

  assign b = item_i.data_byte;

  always_comb begin
    hdr_n = hdr_q;
    id_n  = id_q;
    len_n = len_q;
    ins_n = ins_q;
    fp_n  = fp_q;
    if (cnt_q < spfc_pkg::PosId && b != spfc_pkg::HeaderByte) begin
      hdr_n = 1'b0;
    end
    unique case (cnt_q)
      spfc_pkg::PosId:     id_n  = b;
      spfc_pkg::PosLength: len_n = b;
      spfc_pkg::PosInstr:  ins_n = b;
      spfc_pkg::PosParam:  fp_n  = b;
      default: ;
    endcase
  end

  assign size     = (cnt_q != spfc_pkg::CntMax) ? cnt_q + 9'd1 : spfc_pkg::CntMax;
  assign len_plus = {1'b0, len_n} + spfc_pkg::LenOverhead;
  assign status   = ins_n[spfc_pkg::StatusBit];

  always_comb begin
    priority if (size < spfc_pkg::MinFrame) begin
      verdict = spfc_pkg::VERDICT_TOO_SHORT;
    end else if (!hdr_n) begin
      verdict = spfc_pkg::VERDICT_BAD_HEADER;
    end else if (len_n < spfc_pkg::MinLength) begin
      verdict = spfc_pkg::VERDICT_BAD_LENGTH;
    end else if (size != len_plus) begin
      verdict = spfc_pkg::VERDICT_SIZE_MISMATCH;
    end else if (b != ~sum_q) begin
      verdict = spfc_pkg::VERDICT_BAD_CHECKSUM;
    end else if (req_status_i && !status) begin
      verdict = spfc_pkg::VERDICT_NOT_STATUS;
    end else begin
      verdict = spfc_pkg::VERDICT_OK;
    end
  end

  assign sound = (verdict == spfc_pkg::VERDICT_OK) || (verdict == spfc_pkg::VERDICT_NOT_STATUS);

  always_comb begin
    res_o.verdict          = verdict;
    res_o.servo_id         = id_n;
    res_o.instruction_code = ins_n;
    res_o.length_field     = len_n;
    res_o.is_status        = status;
    res_o.servo_error      = (sound && status && len_n >= spfc_pkg::MinLengthParm) ? fp_n : 8'd0;
    res_o.param_count      = sound ? len_n - spfc_pkg::MinLength : 8'd0;
  end

  // state update, whole frame state clears on the final byte
  always_comb begin
    cnt_d = cnt_q;
    hdr_d = hdr_q;
    sum_d = sum_q;
    id_d  = id_q;
    len_d = len_q;
    ins_d = ins_q;
    fp_d  = fp_q;
    if (adv_i) begin
      if (item_i.last_byte) begin
        cnt_d = '0;
        hdr_d = 1'b1;
        sum_d = '0;
        id_d  = '0;
        len_d = '0;
        ins_d = '0;
        fp_d  = '0;
      end else begin
        hdr_d = hdr_n;
        id_d  = id_n;
        len_d = len_n;
        ins_d = ins_n;
        fp_d  = fp_n;
        if (cnt_q >= spfc_pkg::PosId) begin
          sum_d = sum_q + b;
        end
        if (cnt_q != spfc_pkg::CntMax) begin
          cnt_d = cnt_q + 9'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      hdr_q <= 1'b1;
      sum_q <= '0;
      id_q  <= '0;
      len_q <= '0;
      ins_q <= '0;
      fp_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      hdr_q <= hdr_d;
      sum_q <= sum_d;
      id_q  <= id_d;
      len_q <= len_d;
      ins_q <= ins_d;
      fp_q  <= fp_d;
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && item_i.last_byte |=> cnt_q == '0 && sum_q == '0 && hdr_q)
    else $error("frame state not cleared after final byte");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && !item_i.last_byte && cnt_q != spfc_pkg::CntMax |=> cnt_q == $past(cnt_q) + 9'd1)
    else $error("byte count did not advance");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(cnt_q) && $stable(sum_q))
    else $error("frame state moved without a byte");

endmodule

// ----- hw/rtl/spfc_output_reg.sv -----
module spfc_output_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  spfc_pkg::result_t res_i,
  output logic              space_o,
  spfc_out_if.source        out_o
);

  logic              valid_q, valid_d;
  spfc_pkg::result_t res_q;

  assign space_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid            = valid_q;
  assign out_o.verdict          = res_q.verdict;
  assign out_o.servo_id         = res_q.servo_id;
  assign out_o.instruction_code = res_q.instruction_code;
  assign out_o.length_field     = res_q.length_field;
  assign out_o.is_status        = res_q.is_status;
  assign out_o.servo_error      = res_q.servo_error;
  assign out_o.param_count      = res_q.param_count;

endmodule

// ----- hw/rtl/servo_packet_frame_checker.sv -----
// channel   dir  payload                                          role
// in_i      in   data_byte[7:0], last_byte                        received frame bytes
// out_o     out  verdict[2:0], servo_id, instruction_code,        one result per frame
//                length_field, is_status, servo_error, param_count
// cfg       in   cfg_we_i, cfg_wdata_i                            require_status_reply
//
// one byte per cycle sustained while no final byte waits on a full result register; a final
// byte's result is loaded into the result register as that byte leaves the input register
// rst_ni clears the frame state, the status-reply flag and both valid flags
// a non-final byte never waits on out_o; a final byte waits in the input register
// only while the result register holds a result not yet taken
module servo_packet_frame_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  spfc_in_if.sink    in_i,
  spfc_out_if.source out_o,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i
);

  logic              req_status_q;
  logic              item_vld;
  spfc_pkg::item_t   item;
  spfc_pkg::result_t res;
  logic              out_space;
  logic              adv;

  // configuration register, only to be written while idle; the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_status_q <= 1'b0;
    end else if (cfg_we_i) begin
      req_status_q <= cfg_wdata_i;
    end
  end

  // a held byte moves on unless it is final and the result slot is still full
  assign adv = item_vld && (!item.last_byte || out_space);

  spfc_input_reg u_input_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .adv_i   (adv),
    .valid_o (item_vld),
    .item_o  (item)
  );

  // frame state, checks and decoded fields
  spfc_frame_core u_frame_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .item_i       (item),
    .req_status_i (req_status_q),
    .res_o        (res)
  );

  // result register, loaded on the final byte only
  spfc_output_reg u_output_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv && item.last_byte),
    .res_i   (res),
    .space_o (out_space),
    .out_o   (out_o)
  );

  a_final_needs_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && item.last_byte |-> out_space)
    else $error("final byte advanced into a full result register");

  a_result_follows_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && item.last_byte |=> out_o.valid)
    else $error("no result after the final byte");

endmodule
